FILE: rtl/clcd_pkg.sv
// Shared types, codes and constant tables for the character LCD write sequencer.
// Depends on nothing; every other file in rtl imports it.
package clcd_pkg;

  // Width of the elapsed-tick counter and its saturation value.
  localparam int WAIT_BITS = 24;
  localparam logic [WAIT_BITS-1:0] WAIT_MASK = {WAIT_BITS{1'b1}};

  // Widths of a wait in microseconds and of ticks per microsecond.
  localparam int US_W   = 14;
  localparam int TPU_W  = 8;
  localparam int PROD_W = US_W + TPU_W;

  // Fixed waits in microseconds.
  localparam logic [US_W-1:0] POWERUP_US = 14'd15000;
  localparam logic [US_W-1:0] GAP_LONG_US  = 14'd5000;
  localparam logic [US_W-1:0] GAP_SHORT_US = 14'd160;
  localparam logic [US_W-1:0] GAP_CLEAR_US = 14'd1600;

  // Sequencer phases.
  typedef enum logic [2:0] {
    PH_POWERUP,
    PH_SETUP,
    PH_HIGH,
    PH_SETTLE,
    PH_GAP,
    PH_IDLE
  } phase_t;

  // Sequence step codes.
  localparam logic [3:0] STEP_INIT_FIRST = 4'd0;
  localparam logic [3:0] STEP_INIT_2     = 4'd1;
  localparam logic [3:0] STEP_INIT_3     = 4'd2;
  localparam logic [3:0] STEP_INIT_LAST  = 4'd6;
  localparam logic [3:0] STEP_NONE       = 4'd7;
  localparam logic [3:0] STEP_CLR_A      = 4'd8;
  localparam logic [3:0] STEP_CLR_B      = 4'd9;

  // Request kinds.
  localparam logic [1:0] KIND_TICK    = 2'd0;
  localparam logic [1:0] KIND_COMMAND = 2'd1;
  localparam logic [1:0] KIND_CHAR    = 2'd2;
  localparam logic [1:0] KIND_CLEAR   = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_TICKS_PER_US = 2'd0;
  localparam logic [1:0] REG_PULSE_US     = 2'd1;
  localparam logic [1:0] REG_SETTLE_US    = 2'd2;

  // Panel command bytes.
  localparam logic [7:0] CMD_WAKE     = 8'h30;
  localparam logic [7:0] CMD_FUNC_SET = 8'h38;
  localparam logic [7:0] CMD_SHIFT    = 8'h10;
  localparam logic [7:0] CMD_DISP_ON  = 8'h0C;
  localparam logic [7:0] CMD_ENTRY    = 8'h06;
  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [7:0] CMD_HOME     = 8'h02;

  // Timing configuration as one bundle.
  typedef struct packed {
    logic [TPU_W-1:0] ticks_per_us;
    logic [7:0]       pulse_us;
    logic [11:0]      settle_us;
  } timing_cfg_t;

  // Timer status returned to the sequencer.
  typedef struct packed {
    logic                 expired;
    logic [WAIT_BITS-1:0] count_inc;
  } timer_stat_t;

  // Byte sent at each power-up step.
  function automatic logic [7:0] init_byte(input logic [3:0] step);
    logic [7:0] b;
    case (step)
      4'd3:    b = CMD_FUNC_SET;
      4'd4:    b = CMD_SHIFT;
      4'd5:    b = CMD_DISP_ON;
      4'd6:    b = CMD_ENTRY;
      default: b = CMD_WAKE;
    endcase
    return b;
  endfunction

  // Gap after a byte's settle time, zero where there is none.
  function automatic logic [US_W-1:0] gap_us(input logic [3:0] step);
    logic [US_W-1:0] g;
    case (step)
      STEP_INIT_FIRST: g = GAP_LONG_US;
      STEP_INIT_2:     g = GAP_SHORT_US;
      STEP_INIT_3:     g = GAP_SHORT_US;
      STEP_CLR_A:      g = GAP_CLEAR_US;
      STEP_CLR_B:      g = GAP_CLEAR_US;
      default:         g = '0;
    endcase
    return g;
  endfunction

endpackage

FILE: rtl/char_lcd_write_sequencer_core.sv
// Character LCD write sequencer: init, byte writes and clears on an 8-bit panel.
// Depends on clcd_pkg and instantiates clcd_wait_timer.
//
// Usage:
//   Every request on the input channel (kind, byte_value) is one timing tick,
//   and each produces exactly one result on the output channel carrying the
//   panel pin levels for that tick (bus_data, reg_select, enable_pin) with the
//   ready_res and dropped flags. A command, character or clear request taken
//   while the block is busy is dropped and flagged; a plain tick never is.
//   The result appears in the cycle after acceptance. Throughput
//   is one request per cycle: in_ready stays high while the output register is
//   empty or being emptied, so the sequencer state and the single output
//   register set the rate. When the receiver stalls, in_ready falls and the
//   sequencer holds, since time only advances with accepted requests.
//   Timing registers are written on the cfg channel (index 0 ticks_per_us,
//   1 pulse_us, 2 settle_us; index 3 ignored), and cfg_ready is always high.
//   Synchronous reset restores the register defaults, empties the output
//   register and restarts the power-up sequence from its 15 ms wait.
module char_lcd_write_sequencer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [7:0]  byte_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  bus_data,
  output logic        reg_select,
  output logic        enable_pin,
  output logic        ready_res,
  output logic        dropped,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data
);
  import clcd_pkg::*;

  timing_cfg_t          cfg;
  phase_t               phase, phase_next, phase_req;
  logic [WAIT_BITS-1:0] wait_count, wait_count_next, count_req;
  logic [3:0]           seq_step, seq_step_next, step_req;
  logic [7:0]           held_byte, held_byte_next, byte_req;
  logic                 held_rs, held_rs_next, rs_req;
  logic                 drop_req;
  logic                 accept;
  timer_stat_t          tstat;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ticks_per_us <= 8'd50;
      cfg.pulse_us     <= 8'd6;
      cfg.settle_us    <= 12'd40;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TICKS_PER_US: cfg.ticks_per_us <= cfg_data[7:0];
        REG_PULSE_US:     cfg.pulse_us     <= cfg_data[7:0];
        REG_SETTLE_US:    cfg.settle_us    <= cfg_data;
        default:          ;
      endcase
    end
  end

  // Take the request first: it may start a write from idle.
  always_comb begin
    phase_req = phase;
    count_req = wait_count;
    step_req  = seq_step;
    byte_req  = held_byte;
    rs_req    = held_rs;
    drop_req  = 1'b0;
    if (kind != KIND_TICK) begin
      if (phase != PH_IDLE) begin
        drop_req = 1'b1;
      end else if (kind == KIND_CLEAR) begin
        step_req  = STEP_CLR_A;
        byte_req  = CMD_CLEAR;
        rs_req    = 1'b0;
        phase_req = PH_SETUP;
        count_req = '0;
      end else begin
        step_req  = STEP_NONE;
        byte_req  = byte_value;
        rs_req    = (kind == KIND_CHAR);
        phase_req = PH_SETUP;
        count_req = '0;
      end
    end
  end

  clcd_wait_timer u_timer (
    .phase      (phase_req),
    .seq_step   (step_req),
    .cfg        (cfg),
    .wait_count (count_req),
    .stat       (tstat)
  );

  // Next state: advance the elapsed count and move on when the phase ends.
  always_comb begin
    phase_next      = phase_req;
    wait_count_next = count_req;
    seq_step_next   = step_req;
    held_byte_next  = byte_req;
    held_rs_next    = rs_req;
    if (phase_req != PH_IDLE) begin
      wait_count_next = tstat.count_inc;
      if (tstat.expired) begin
        wait_count_next = '0;
        unique case (phase_req)
          PH_POWERUP: begin
            seq_step_next  = STEP_INIT_FIRST;
            held_byte_next = init_byte(STEP_INIT_FIRST);
            held_rs_next   = 1'b0;
            phase_next     = PH_SETUP;
          end
          PH_SETUP:  phase_next = PH_HIGH;
          PH_HIGH:   phase_next = PH_SETTLE;
          PH_SETTLE, PH_GAP: begin
            if (phase_req == PH_SETTLE && gap_us(step_req) != '0) begin
              phase_next = PH_GAP;
            end else if (step_req < STEP_INIT_LAST) begin
              // Next byte of the power-up sequence.
              seq_step_next  = step_req + 4'd1;
              held_byte_next = init_byte(step_req + 4'd1);
              held_rs_next   = 1'b0;
              phase_next     = PH_SETUP;
            end else if (step_req == STEP_CLR_A) begin
              // Second half of a clear returns the cursor home.
              seq_step_next  = STEP_CLR_B;
              held_byte_next = CMD_HOME;
              held_rs_next   = 1'b0;
              phase_next     = PH_SETUP;
            end else begin
              seq_step_next = STEP_NONE;
              phase_next    = PH_IDLE;
            end
          end
          default: phase_next = PH_IDLE;
        endcase
      end
    end
  end

  // Sequencer state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_POWERUP;
      wait_count <= '0;
      seq_step   <= STEP_INIT_FIRST;
      held_byte  <= '0;
      held_rs    <= 1'b0;
    end else if (accept) begin
      phase      <= phase_next;
      wait_count <= wait_count_next;
      seq_step   <= seq_step_next;
      held_byte  <= held_byte_next;
      held_rs    <= held_rs_next;
    end
  end

  // Output register: pin levels seen after the request is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      bus_data   <= byte_req;
      reg_select <= rs_req;
      enable_pin <= (phase_req == PH_HIGH);
      ready_res  <= (phase_req == PH_IDLE);
      dropped    <= drop_req;
    end
  end

endmodule

FILE: rtl/clcd_wait_timer.sv
// Wait length and expiry check for the current phase of the sequencer.
// Depends on clcd_pkg for the phase type, timing bundle and fixed waits.
module clcd_wait_timer (
  input  clcd_pkg::phase_t               phase,
  input  logic [3:0]                     seq_step,
  input  clcd_pkg::timing_cfg_t          cfg,
  input  logic [clcd_pkg::WAIT_BITS-1:0] wait_count,
  output clcd_pkg::timer_stat_t          stat
);
  import clcd_pkg::*;

  localparam int CMP_W = (PROD_W > WAIT_BITS) ? PROD_W : WAIT_BITS;

  logic [US_W-1:0]      phase_us;
  logic [PROD_W-1:0]    prod;
  logic [WAIT_BITS-1:0] target;
  logic [WAIT_BITS-1:0] count_inc;

  // Length of the current phase in microseconds.
  always_comb begin
    unique case (phase)
      PH_POWERUP: phase_us = POWERUP_US;
      PH_SETUP:   phase_us = US_W'(cfg.pulse_us);
      PH_HIGH:    phase_us = US_W'(cfg.pulse_us);
      PH_SETTLE:  phase_us = US_W'(cfg.settle_us);
      PH_GAP:     phase_us = gap_us(seq_step);
      default:    phase_us = '0;
    endcase
  end

  // Scale to ticks and saturate to what the counter can hold.
  assign prod = PROD_W'(phase_us) * PROD_W'(cfg.ticks_per_us);

  always_comb begin
    if (CMP_W'(prod) > CMP_W'(WAIT_MASK)) begin
      target = WAIT_MASK;
    end else begin
      target = WAIT_BITS'(prod);
    end
  end

  // Count one more tick, holding at the top.
  always_comb begin
    if (wait_count != WAIT_MASK) begin
      count_inc = wait_count + 1'b1;
    end else begin
      count_inc = wait_count;
    end
  end

  assign stat.count_inc = count_inc;
  assign stat.expired   = (count_inc >= target);

endmodule
